FILE: hdl/mbec_pkg.sv
// mbec_pkg: shared types and constants of the mandelbrot escape count unit
// payload structs, configuration layout, controller/datapath command and status
// no dependencies
`default_nettype none

package mbec_pkg;

  // parameter defaults
  localparam int unsigned MaxGridRadiusDefault = 1024;
  localparam int unsigned CountWidthDefault    = 16;
  localparam int unsigned CoordWidthDefault    = 32;

  // fixed field widths
  localparam int unsigned PixelW   = 12;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned GridW    = 11;
  localparam int unsigned MagW     = 31;
  localparam int unsigned FracBits = 28;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDX_CENTER_RE       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_CENTER_IM       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_HALF_SPAN       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_PIXEL_STEP      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDX_ESCAPE_RADIUS   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IDX_ITERATION_LIMIT = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_IDX_GRID_RADIUS     = 3'd6;

  // configuration reset values
  localparam logic signed [31:0] CENTER_RE_RST       = 32'sd0;
  localparam logic signed [31:0] CENTER_IM_RST       = 32'sd0;
  localparam logic [MagW-1:0]    HALF_SPAN_RST       = 31'd536870912;
  localparam logic [MagW-1:0]    PIXEL_STEP_RST      = 31'd1048576;
  localparam logic [MagW-1:0]    ESCAPE_RADIUS_RST   = 31'd536870912;
  localparam logic [CountW-1:0]  ITERATION_LIMIT_RST = 16'd255;
  localparam logic [GridW-1:0]   GRID_RADIUS_RST     = 11'd512;

  typedef struct packed {
    logic [PixelW-1:0] pixel_row;
    logic [PixelW-1:0] pixel_col;
  } mbec_in_t;

  typedef struct packed {
    logic [CountW-1:0] escape_count;
    logic              out_of_range;
  } mbec_out_t;

  typedef struct packed {
    logic signed [31:0] center_re;
    logic signed [31:0] center_im;
    logic [MagW-1:0]    half_span;
    logic [MagW-1:0]    pixel_step;
    logic [MagW-1:0]    escape_radius;
    logic [CountW-1:0]  iteration_limit;
    logic [GridW-1:0]   grid_radius;
  } mbec_cfg_t;

  typedef struct packed {
    logic load_in;
    logic setup;
    logic coord;
    logic mul;
    logic upd;
    logic load_out;
  } mbec_cmd_t;

  typedef struct packed {
    logic oor;
    logic escaped;
    logic at_limit;
  } mbec_sts_t;

endpackage

`default_nettype wire

FILE: hdl/mandelbrot_escape_count_unit.sv
// mandelbrot_escape_count_unit: top level, escape-time count for one grid pixel
// joins mbec_cfg_regs, mbec_ctrl and mbec_datapath; depends on mbec_pkg
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | to unit   | in_valid_i / in_stall_o  | in_data_i  (pixel_row, pixel_col)
//   out     | from unit | out_valid_o / out_stall_i| out_data_o (escape_count, out_of_range)
//   cfg     | to unit   | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// one pixel at a time: an accepted pixel goes through setup and coordinate
// mapping, then alternates the multiply and update states until it escapes or
// runs the whole limit, then reaches finish; an out of range pixel skips the
// loop. reset clears the controller and loads configuration defaults.
// the output register lets the next pixel be accepted while a result waits;
// a stalled result only holds the unit once the next result is ready.
`default_nettype none

module mandelbrot_escape_count_unit #(
  parameter int unsigned MAX_GRID_RADIUS = mbec_pkg::MaxGridRadiusDefault,
  parameter int unsigned COUNT_WIDTH     = mbec_pkg::CountWidthDefault,
  parameter int unsigned COORD_WIDTH     = mbec_pkg::CoordWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire mbec_pkg::mbec_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mbec_pkg::mbec_out_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mbec_pkg::CfgDataW-1:0] cfg_wdata_i
);

  mbec_pkg::mbec_cfg_t cfg;
  mbec_pkg::mbec_cmd_t cmd;
  mbec_pkg::mbec_sts_t sts;

  mbec_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  mbec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbec_datapath #(
    .MAX_GRID_RADIUS(MAX_GRID_RADIUS),
    .COUNT_WIDTH    (COUNT_WIDTH),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .cfg_i     (cfg),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

FILE: hdl/mbec_cfg_regs.sv
// mbec_cfg_regs: configuration register file of the escape count unit
// write-only port, one register per index, index 7 unused; depends on mbec_pkg
`default_nettype none

module mbec_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mbec_pkg::CfgDataW-1:0] cfg_wdata_i,
  output mbec_pkg::mbec_cfg_t                cfg_o
);

  mbec_pkg::mbec_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mbec_pkg::CFG_IDX_CENTER_RE:       cfg_d.center_re       = $signed(cfg_wdata_i);
        mbec_pkg::CFG_IDX_CENTER_IM:       cfg_d.center_im       = $signed(cfg_wdata_i);
        mbec_pkg::CFG_IDX_HALF_SPAN:       cfg_d.half_span       = cfg_wdata_i[30:0];
        mbec_pkg::CFG_IDX_PIXEL_STEP:      cfg_d.pixel_step      = cfg_wdata_i[30:0];
        mbec_pkg::CFG_IDX_ESCAPE_RADIUS:   cfg_d.escape_radius   = cfg_wdata_i[30:0];
        mbec_pkg::CFG_IDX_ITERATION_LIMIT: cfg_d.iteration_limit = cfg_wdata_i[15:0];
        mbec_pkg::CFG_IDX_GRID_RADIUS:     cfg_d.grid_radius     = cfg_wdata_i[10:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_re       <= mbec_pkg::CENTER_RE_RST;
      cfg_q.center_im       <= mbec_pkg::CENTER_IM_RST;
      cfg_q.half_span       <= mbec_pkg::HALF_SPAN_RST;
      cfg_q.pixel_step      <= mbec_pkg::PIXEL_STEP_RST;
      cfg_q.escape_radius   <= mbec_pkg::ESCAPE_RADIUS_RST;
      cfg_q.iteration_limit <= mbec_pkg::ITERATION_LIMIT_RST;
      cfg_q.grid_radius     <= mbec_pkg::GRID_RADIUS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/mbec_ctrl.sv
// mbec_ctrl: controller state machine of the escape count unit
// sequences setup, iteration and result hand-off; depends on mbec_pkg
`default_nettype none

module mbec_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  input  wire mbec_pkg::mbec_sts_t sts_i,
  output mbec_pkg::mbec_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_COORD  = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_UPD    = 6'b010000,
    ST_FINISH = 6'b100000
  } mbec_state_e;

  mbec_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_COORD;
      end
      ST_COORD: begin
        cmd_o.coord = 1'b1;
        state_d     = sts_i.oor ? ST_FINISH : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = (sts_i.escaped || sts_i.at_limit) ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        // hand off once the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hdl/mbec_datapath.sv
// mbec_datapath: coordinate mapping, complex square iteration and escape test
// three registered multipliers feed a saturating update; depends on mbec_pkg
`default_nettype none

module mbec_datapath #(
  parameter int unsigned MAX_GRID_RADIUS = mbec_pkg::MaxGridRadiusDefault,
  parameter int unsigned COUNT_WIDTH     = mbec_pkg::CountWidthDefault,
  parameter int unsigned COORD_WIDTH     = mbec_pkg::CoordWidthDefault
) (
  input  wire logic                clk_i,
  input  wire mbec_pkg::mbec_cfg_t cfg_i,
  input  wire mbec_pkg::mbec_in_t  in_data_i,
  input  wire mbec_pkg::mbec_cmd_t cmd_i,
  output mbec_pkg::mbec_sts_t      sts_o,
  output mbec_pkg::mbec_out_t      out_data_o
);

  localparam int unsigned CW  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam int unsigned PW  = 2 * CW;
  localparam int unsigned SW  = 2 * CW + 2;
  localparam int unsigned EW  = 68;
  localparam int unsigned CpW = 46;
  localparam int unsigned PrW = mbec_pkg::MagW + mbec_pkg::PixelW;
  localparam int unsigned R2W = 2 * mbec_pkg::MagW;
  localparam int unsigned GW  = mbec_pkg::GridW;
  localparam int unsigned NW  = mbec_pkg::CountW;

  localparam int unsigned RadCapI   = (MAX_GRID_RADIUS > 2047) ? 2047 : MAX_GRID_RADIUS;
  localparam logic [GW-1:0] RadCap  = GW'(RadCapI);
  localparam logic [NW-1:0] LimitCap =
    (COUNT_WIDTH >= 16) ? 16'hFFFF : NW'((1 << COUNT_WIDTH) - 1);

  localparam logic signed [EW-1:0] CoordMaxE = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [EW-1:0] CoordMinE = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > CoordMaxE) begin
      r = CoordMaxE[CW-1:0];
    end else if (v < CoordMinE) begin
      r = CoordMinE[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  mbec_pkg::mbec_in_t      pix_q;
  logic [PrW-1:0]          prod_col_q, prod_row_q;
  logic [R2W-1:0]          r2_q;
  logic                    oor_q;
  logic signed [CW-1:0]    cr_q, ci_q, zr_q, zi_q;
  logic signed [PW-1:0]    xx_q, yy_q, xy_q;
  logic [NW-1:0]           n_q;
  logic [NW-1:0]           res_count_q;
  logic                    res_oor_q;
  mbec_pkg::mbec_out_t     out_q;

  logic [GW-1:0]           rad;
  logic [mbec_pkg::PixelW-1:0] span;
  logic                    oor_d;
  logic [NW-1:0]           limit;
  logic signed [CpW-1:0]   cr_w, ci_w;
  logic signed [SW-1:0]    diff, re_sh, xy_w, im_sh;
  logic signed [EW-1:0]    re_sum, im_sum;
  logic [63:0]             mag;
  logic                    escaped, at_limit;

  // grid bounds and clipped iteration limit
  assign rad   = (cfg_i.grid_radius > RadCap) ? RadCap : cfg_i.grid_radius;
  assign span  = {rad, 1'b0};
  assign oor_d = (pix_q.pixel_row > span) || (pix_q.pixel_col > span);
  assign limit = (cfg_i.iteration_limit > LimitCap) ? LimitCap : cfg_i.iteration_limit;

  // pixel center, exact before saturation
  assign cr_w = CpW'(cfg_i.center_re) - $signed(CpW'(cfg_i.half_span))
              + $signed(CpW'(prod_col_q));
  assign ci_w = CpW'(cfg_i.center_im) + $signed(CpW'(cfg_i.half_span))
              - $signed(CpW'(prod_row_q));

  // z*z + c, floor shifts back to Q4.28, cross term doubled by shifting one less
  assign diff   = SW'(xx_q) - SW'(yy_q);
  assign re_sh  = diff >>> mbec_pkg::FracBits;
  assign xy_w   = SW'(xy_q);
  assign im_sh  = xy_w >>> (mbec_pkg::FracBits - 1);
  assign re_sum = EW'(re_sh) + EW'(cr_q);
  assign im_sum = EW'(im_sh) + EW'(ci_q);

  // products hold the squares of the current z, which is what the escape test needs
  assign mag      = 64'($unsigned(xx_q)) + 64'($unsigned(yy_q));
  assign escaped  = mag > 64'(r2_q);
  assign at_limit = (n_q == limit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pix_q <= in_data_i;
    end
    if (cmd_i.setup) begin
      prod_col_q <= PrW'(cfg_i.pixel_step) * PrW'(pix_q.pixel_col);
      prod_row_q <= PrW'(cfg_i.pixel_step) * PrW'(pix_q.pixel_row);
      r2_q       <= R2W'(cfg_i.escape_radius) * R2W'(cfg_i.escape_radius);
      oor_q      <= oor_d;
    end
    if (cmd_i.coord) begin
      cr_q        <= sat_coord(EW'(cr_w));
      ci_q        <= sat_coord(EW'(ci_w));
      zr_q        <= '0;
      zi_q        <= '0;
      n_q         <= '0;
      res_count_q <= '0;
      res_oor_q   <= oor_q;
    end
    if (cmd_i.mul) begin
      xx_q <= PW'(zr_q) * PW'(zr_q);
      yy_q <= PW'(zi_q) * PW'(zi_q);
      xy_q <= PW'(zr_q) * PW'(zi_q);
    end
    if (cmd_i.upd) begin
      if (escaped) begin
        res_count_q <= n_q;
      end else if (!at_limit) begin
        zr_q <= sat_coord(re_sum);
        zi_q <= sat_coord(im_sum);
        n_q  <= n_q + 1'b1;
      end
    end
    if (cmd_i.load_out) begin
      out_q.escape_count <= res_count_q;
      out_q.out_of_range <= res_oor_q;
    end
  end

  assign sts_o.oor      = oor_q;
  assign sts_o.escaped  = escaped;
  assign sts_o.at_limit = at_limit;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

FILE: hdl/mbec_checker.sv
// mbec_checker: port-level checks of the escape count unit, bound to the top level
// depends on mbec_pkg and mandelbrot_escape_count_unit
`default_nettype none

module mbec_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_i,
  input wire logic                out_valid_i,
  input wire logic                out_stall_i,
  input wire mbec_pkg::mbec_out_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_i;

  // one pixel in flight: the input side closes right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_i)
    else $error("input not stalled after accepted transaction");

  // no result can be produced in the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared too early after accept");

  a_oor_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.out_of_range |-> out_data_i.escape_count == '0)
    else $error("out of range pixel with nonzero count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result dropped or changed");

endmodule

bind mandelbrot_escape_count_unit mbec_checker u_mbec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);

`default_nettype wire
